/* design/sbcf_pkg.sv */
// ----------------------------------------------------------------------------
// sbcf_pkg: shared types and constants of the sprite blitter
// Register indexes, config record, payload widths and dimension clamping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbcf_pkg;

   // payload widths
   localparam int PIXEL_W = 32;
   localparam int INDEX_W = 22;
   localparam int DIM_W   = 12;
   localparam int SPR_W   = 9;

   // alpha byte position in the ARGB word
   localparam int         ALPHA_LSB  = 24;
   localparam logic [7:0] ALPHA_NONE = 8'h00;

   // largest frame buffer dimension honored
   localparam logic [DIM_W-1:0] BUF_DIM_MAX = 12'd2048;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_BUFFER_WIDTH  = 3'd0,
      REG_BUFFER_HEIGHT = 3'd1,
      REG_SPRITE_WIDTH  = 3'd2,
      REG_SPRITE_HEIGHT = 3'd3,
      REG_PLACE_X       = 3'd4,
      REG_PLACE_Y       = 3'd5,
      REG_SCAN_LTR      = 3'd6
   } csr_index_type;

   // frame and placement settings seen by the mapper
   typedef struct packed {
      logic [DIM_W-1:0] buffer_width;
      logic [DIM_W-1:0] buffer_height;
      logic [DIM_W-1:0] place_x;
      logic [DIM_W-1:0] place_y;
      logic             scan_left_to_right;
   } cfg_type;

   // mapper verdict for one pixel
   typedef struct packed {
      logic               hit;
      logic [INDEX_W-1:0] dest_index;
   } map_result_type;

   // zero counts as one, oversize counts as the maximum
   function automatic logic [DIM_W-1:0] clamp_buf_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > BUF_DIM_MAX) begin
         r = BUF_DIM_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

/* design/sbcf_req_if.sv */
// ----------------------------------------------------------------------------
// sbcf_req_if: sprite pixel request channel
// Valid/ready channel carrying one ARGB pixel and the first-pixel mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sbcf_req_if
   import sbcf_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_argb;
   logic               first_pixel;

   modport source (output valid, output pixel_argb, output first_pixel, input ready);
   modport sink   (input valid, input pixel_argb, input first_pixel, output ready);
endinterface

/* design/sbcf_rsp_if.sv */
// ----------------------------------------------------------------------------
// sbcf_rsp_if: frame buffer write channel
// Valid/ready channel carrying a linear buffer index and the pixel to store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sbcf_rsp_if
   import sbcf_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] dest_index;
   logic [PIXEL_W-1:0] write_pixel;

   modport source (output valid, output dest_index, output write_pixel, input ready);
   modport sink   (input valid, input dest_index, input write_pixel, output ready);
endinterface

/* design/sbcf_map.sv */
// ----------------------------------------------------------------------------
// sbcf_map: destination mapping and clipping
// Mirrors and offsets the source position, clips against the buffer and the
// alpha key, and forms the linear index row * width + column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbcf_map
   import sbcf_pkg::*;
#(
   parameter int MAX_SPRITE_DIM = 256
) (
   input  cfg_type                          cfg,
   input  logic [$clog2(MAX_SPRITE_DIM):0]  sprite_width,
   input  logic [$clog2(MAX_SPRITE_DIM)-1:0] col,
   input  logic [$clog2(MAX_SPRITE_DIM)-1:0] row,
   input  logic [PIXEL_W-1:0]               pixel_argb,
   output map_result_type                   result
);

   localparam int CW = $clog2(MAX_SPRITE_DIM);
   localparam int OW = CW + 2;                      // signed sprite offset
   localparam int XW = ((OW > DIM_W) ? OW : DIM_W) + 1;

   logic signed [DIM_W-1:0] px, py;
   logic signed [OW-1:0]    col_s, row_s, sw_s, off_x;
   logic signed [XW-1:0]    dx, dy, bw_s, bh_s;
   logic [DIM_W-1:0]        bw, bh;
   logic                    in_frame, opaque;
   logic [2*DIM_W-1:0]      prod;

   assign bw = clamp_buf_dim(cfg.buffer_width);
   assign bh = clamp_buf_dim(cfg.buffer_height);
   assign px = signed'(cfg.place_x);
   assign py = signed'(cfg.place_y);

   // source offsets, mirrored within the sprite width when scanning right to left
   assign col_s = signed'(OW'(col));
   assign row_s = signed'(OW'(row));
   assign sw_s  = signed'(OW'(sprite_width));
   assign off_x = cfg.scan_left_to_right ? col_s : (sw_s - col_s - signed'(OW'(1)));

   assign dx   = XW'(px) + XW'(off_x);
   assign dy   = XW'(py) + XW'(row_s);
   assign bw_s = signed'(XW'(bw));
   assign bh_s = signed'(XW'(bh));

   // clip to the buffer and drop fully transparent pixels
   assign in_frame = !dx[XW-1] && (dx < bw_s) && !dy[XW-1] && (dy < bh_s);
   assign opaque   = pixel_argb[ALPHA_LSB +: 8] != ALPHA_NONE;

   // linear index, kept to the index width
   assign prod = (2*DIM_W)'(dy[DIM_W-1:0]) * (2*DIM_W)'(bw);

   assign result.hit        = in_frame && opaque;
   assign result.dest_index = INDEX_W'(prod + (2*DIM_W)'(dx[DIM_W-1:0]));

endmodule

/* design/sprite_blit_clip_flip_core.sv */
// ----------------------------------------------------------------------------
// sprite_blit_clip_flip_core: sprite blit with clipping, mirroring and color key
// Path: an accepted pixel request passes the input register, then the mapper
// and multiplier into the result register; clipped pixels give no write.
// Throughput: one pixel request per cycle unless the write channel stalls.
// Reset: synchronous; clears counters and valids, loads register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_blit_clip_flip_core
   import sbcf_pkg::*;
#(
   parameter int MAX_SPRITE_DIM = 256
) (
   input  logic              clock,
   input  logic              reset,
   sbcf_req_if.sink          req_chan,
   sbcf_rsp_if.source        rsp_chan,
   input  logic              csr_wr_en,
   input  logic [2:0]        csr_index,
   input  logic [DIM_W-1:0]  csr_wr_data
);

   localparam int CW  = $clog2(MAX_SPRITE_DIM);
   localparam int SPW = CW + 1;

   // configuration registers
   logic [DIM_W-1:0] buf_w_ff, buf_h_ff, place_x_ff, place_y_ff;
   logic [SPR_W-1:0] spr_w_ff, spr_h_ff;
   logic             scan_ltr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_w_ff    <= 12'd640;
         buf_h_ff    <= 12'd480;
         spr_w_ff    <= 9'd16;
         spr_h_ff    <= 9'd16;
         place_x_ff  <= '0;
         place_y_ff  <= '0;
         scan_ltr_ff <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_BUFFER_WIDTH:  buf_w_ff    <= csr_wr_data;
            REG_BUFFER_HEIGHT: buf_h_ff    <= csr_wr_data;
            REG_SPRITE_WIDTH:  spr_w_ff    <= csr_wr_data[SPR_W-1:0];
            REG_SPRITE_HEIGHT: spr_h_ff    <= csr_wr_data[SPR_W-1:0];
            REG_PLACE_X:       place_x_ff  <= csr_wr_data;
            REG_PLACE_Y:       place_y_ff  <= csr_wr_data;
            REG_SCAN_LTR:      scan_ltr_ff <= csr_wr_data[0];
            default:           ;
         endcase
      end
   end

   // effective sprite size: zero counts as one, oversize as the maximum
   logic [SPW-1:0] sw, sh;

   always_comb begin
      if (spr_w_ff == '0) begin
         sw = SPW'(1);
      end else if (32'(spr_w_ff) > MAX_SPRITE_DIM) begin
         sw = SPW'(MAX_SPRITE_DIM);
      end else begin
         sw = SPW'(spr_w_ff);
      end
      if (spr_h_ff == '0) begin
         sh = SPW'(1);
      end else if (32'(spr_h_ff) > MAX_SPRITE_DIM) begin
         sh = SPW'(MAX_SPRITE_DIM);
      end else begin
         sh = SPW'(spr_h_ff);
      end
   end

   // handshake
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s2_ready, req_accept, s1_move;

   assign s2_ready       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s2_ready;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign s1_move        = s1_valid_ff && s2_ready;

   // source column and row of the accepted request
   logic [CW-1:0]  col_ff, col_in, row_ff, row_in, cur_col, cur_row;
   logic [SPW-1:0] col_nxt, row_nxt;

   always_comb begin
      cur_col = req_chan.first_pixel ? '0 : col_ff;
      cur_row = req_chan.first_pixel ? '0 : row_ff;
      col_nxt = SPW'(cur_col) + SPW'(1);
      row_nxt = SPW'(cur_row) + SPW'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (req_accept) begin
         if (col_nxt >= sw) begin
            col_in = '0;
            row_in = (row_nxt >= sh) ? '0 : row_nxt[CW-1:0];
         end else begin
            col_in = col_nxt[CW-1:0];
            row_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // input register
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic [CW-1:0]      s1_col_ff, s1_row_ff;

   assign s1_valid_in = req_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff <= req_chan.pixel_argb;
         s1_col_ff   <= cur_col;
         s1_row_ff   <= cur_row;
      end
   end

   // mapping and clipping
   cfg_type        cfg;
   map_result_type map_res;

   assign cfg.buffer_width       = buf_w_ff;
   assign cfg.buffer_height      = buf_h_ff;
   assign cfg.place_x            = place_x_ff;
   assign cfg.place_y            = place_y_ff;
   assign cfg.scan_left_to_right = scan_ltr_ff;

   sbcf_map #(
      .MAX_SPRITE_DIM (MAX_SPRITE_DIM)
   ) u_map (
      .cfg          (cfg),
      .sprite_width (sw),
      .col          (s1_col_ff),
      .row          (s1_row_ff),
      .pixel_argb   (s1_pixel_ff),
      .result       (map_res)
   );

   // result register
   logic [INDEX_W-1:0] rsp_index_ff;
   logic [PIXEL_W-1:0] rsp_pixel_ff;

   assign rsp_valid_in = s2_ready ? (s1_valid_ff && map_res.hit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff && map_res.hit) begin
         rsp_index_ff <= map_res.dest_index;
         rsp_pixel_ff <= s1_pixel_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.dest_index  = rsp_index_ff;
   assign rsp_chan.write_pixel = rsp_pixel_ff;

   // checks
   a_write_opaque: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pixel_ff[ALPHA_LSB +: 8] != ALPHA_NONE))
      else $error("write of a transparent pixel");

   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |=> (s1_valid_ff && $stable(s1_pixel_ff)))
      else $error("pending request lost while result stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

endmodule
